// ----- rtl/core/cba_pkg.sv -----
// Package for the contiguous block allocator: command and result word types,
// action codes. No dependencies.
package cba_pkg;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_GET    = 2'd1,
		ACT_DEL    = 2'd2,
		ACT_DEFRAG = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  file_id;
		logic [15:0] size_kb;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  file_id_out;
		logic [9:0]  first_block;
		logic [9:0]  last_block;
		logic        status;
	} rsp_t;

	localparam int unsigned IDX_W = 10;

	// Kilobytes per block; a power of two, so the block count is a shift.
	localparam int unsigned BLOCK_KB = 8;

endpackage

// ----- rtl/core/cba_map_ram.sv -----
// Block map storage: one write port, one registered read port.
// Depends on nothing.
module cba_map_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/contiguous_block_allocator_top.sv -----
// Top level of the contiguous block allocator: sequencer around the block map.
// Depends on cba_pkg and cba_map_ram.
//
// Usage:
//   Command channel: drive cmd with start high; the word is taken at an edge
//   where start is high and busy is low. busy stays high until the result
//   word has been shown.
//   Result channel: rsp is valid for exactly one cycle while done is high;
//   the receiver cannot stall, so it must take the word in that cycle.
// Sequence:
//   After reset the map is cleared by a sweep over every entry, during
//   which busy is high. Add, get and delete with a nonzero file id make a
//   find pass over the map and a decide step; a zero file id goes straight
//   to the result. A successful add or delete then writes the range, block
//   by block. Defragment makes a read/compact pass and, if any tail is
//   freed, a zero-fill pass over it. A result state follows. One command is
//   in flight at a time; the next word is taken once busy drops after done.
//   Each pass goes through the map one entry per cycle (single read port).
// Reset: arst_n clears control state; the map clear sweep then starts.
module contiguous_block_allocator_top #(
	parameter int unsigned NUM_BLOCKS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cba_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output cba_pkg::rsp_t rsp
);
	import cba_pkg::*;

	localparam int unsigned AW = $clog2(NUM_BLOCKS);
	localparam int unsigned CW = AW + 1;
	localparam int unsigned NW = 17;

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_SCAN   = 8'b0000_0100,
		ST_DECIDE = 8'b0000_1000,
		ST_WRITE  = 8'b0001_0000,
		ST_PACK   = 8'b0010_0000,
		ST_FILL   = 8'b0100_0000,
		ST_RESP   = 8'b1000_0000
	} state_t;

	state_t         state_q;
	cmd_t           cmd_q;
	logic [NW-1:0]  need_q;
	logic [CW-1:0]  rd_q;      // read address counter
	logic [CW-1:0]  vis_q;     // index of entry whose data is on rdata
	logic           vis_v_q;   // rdata valid for vis_q
	logic [CW-1:0]  wr_q;      // write pointer
	logic [CW-1:0]  run_q;
	logic           room_q, seen_q;
	logic [AW-1:0]  lo_q, hi_q, room_lo_q;
	logic           ok_q;

	logic           we;
	logic [AW-1:0]  waddr;
	logic [7:0]     wdata;
	logic [7:0]     rdata;

	cba_map_ram #(.DEPTH(NUM_BLOCKS), .AW(AW)) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_q[AW-1:0]),
		.rdata(rdata)
	);

	// Blocks needed: ceil(size/BLOCK_KB), at least one.
	logic [NW-1:0] need_c;
	always_comb begin
		if (cmd.size_kb == 16'd0) begin
			need_c = NW'(1);
		end else begin
			need_c = NW'((32'(cmd.size_kb) - 32'd1) / BLOCK_KB + 32'd1);
		end
	end

	logic [CW-1:0] run_nx;
	assign run_nx = run_q + CW'(1);

	always_comb begin
		we    = 1'b0;
		waddr = wr_q[AW-1:0];
		wdata = 8'd0;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
			end
			ST_WRITE: begin
				we    = 1'b1;
				wdata = (cmd_q.action == ACT_ADD) ? cmd_q.file_id : 8'd0;
			end
			ST_PACK: begin
				we    = vis_v_q && (rdata != 8'd0);
				wdata = rdata;
			end
			ST_FILL: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			wr_q    <= '0;
			rd_q    <= '0;
			vis_v_q <= 1'b0;
			ok_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					wr_q <= wr_q + CW'(1);
					if (wr_q == CW'(NUM_BLOCKS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						need_q  <= need_c;
						rd_q    <= '0;
						vis_v_q <= 1'b0;
						wr_q    <= '0;
						run_q   <= '0;
						room_q  <= 1'b0;
						seen_q  <= 1'b0;
						ok_q    <= 1'b0;
						if (cmd.action == ACT_DEFRAG) begin
							state_q <= ST_PACK;
						end else if (cmd.file_id == 8'd0) begin
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// Advance read; evaluate entry from previous cycle.
					if (rd_q != CW'(NUM_BLOCKS)) begin
						rd_q <= rd_q + CW'(1);
					end
					vis_q   <= rd_q;
					vis_v_q <= (rd_q != CW'(NUM_BLOCKS));
					if (vis_v_q) begin
						if (rdata == cmd_q.file_id) begin
							if (!seen_q) begin
								lo_q <= vis_q[AW-1:0];
							end
							seen_q <= 1'b1;
							hi_q   <= vis_q[AW-1:0];
						end
						if (rdata == 8'd0) begin
							run_q <= run_nx;
							if (!room_q && NW'(run_nx) >= need_q) begin
								room_q    <= 1'b1;
								room_lo_q <= AW'(vis_q + CW'(1) - run_nx);
							end
						end else begin
							run_q <= '0;
						end
					end else if (rd_q == CW'(NUM_BLOCKS)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					vis_v_q <= 1'b0;
					if (cmd_q.action == ACT_ADD) begin
						if (!seen_q && room_q) begin
							lo_q    <= room_lo_q;
							hi_q    <= AW'(NW'(room_lo_q) + need_q - NW'(1));
							wr_q    <= CW'(room_lo_q);
							ok_q    <= 1'b1;
							state_q <= ST_WRITE;
						end else begin
							state_q <= ST_RESP;
						end
					end else begin
						ok_q    <= seen_q;
						wr_q    <= CW'(lo_q);
						state_q <= (seen_q && cmd_q.action == ACT_DEL) ? ST_WRITE : ST_RESP;
					end
				end
				ST_WRITE: begin
					wr_q <= wr_q + CW'(1);
					if (wr_q[AW-1:0] == hi_q) begin
						state_q <= ST_RESP;
					end
				end
				ST_PACK: begin
					// Compact: copy nonzero entries down to wr_q.
					if (rd_q != CW'(NUM_BLOCKS)) begin
						rd_q <= rd_q + CW'(1);
					end
					vis_v_q <= (rd_q != CW'(NUM_BLOCKS));
					if (vis_v_q && rdata != 8'd0) begin
						wr_q <= wr_q + CW'(1);
					end
					if (!vis_v_q && rd_q == CW'(NUM_BLOCKS)) begin
						ok_q    <= 1'b1;
						state_q <= (wr_q == CW'(NUM_BLOCKS)) ? ST_RESP : ST_FILL;
					end
				end
				ST_FILL: begin
					wr_q <= wr_q + CW'(1);
					if (wr_q == CW'(NUM_BLOCKS - 1)) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESP);

	always_comb begin
		rsp.file_id_out = (cmd_q.action == ACT_DEFRAG) ? 8'd0 : cmd_q.file_id;
		rsp.status      = !ok_q;
		if (ok_q && cmd_q.action != ACT_DEFRAG) begin
			rsp.first_block = IDX_W'(lo_q);
			rsp.last_block  = IDX_W'(hi_q);
		end else begin
			rsp.first_block = '0;
			rsp.last_block  = '0;
		end
	end

`ifndef ASSERT_OFF
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result shown while idle");
	a_defrag_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cmd_q.action == ACT_DEFRAG) |-> !rsp.status)
		else $error("defragment failed");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status) |-> (rsp.first_block == '0 && rsp.last_block == '0))
		else $error("failure range not zero");
`endif
endmodule
